// File: hw/rtl/tsvm_pkg.sv
// Shared types and constants of the two-stack integer VM.
// Stack geometry, instruction and status codes, command struct and states.
// No dependencies.
`default_nettype none

package tsvm_pkg;

  localparam int StackDepth = 16;
  localparam int DataWidth  = 32;
  localparam int AddrW      = $clog2(StackDepth);
  localparam int CntW       = $clog2(StackDepth + 1);
  localparam int CmdQDepth  = 2;

  typedef logic [DataWidth-1:0] data_t;
  typedef logic [CntW-1:0]      cnt_t;

  // Raw instruction codes on the kind field
  localparam logic [3:0] KindPush   = 4'd0;
  localparam logic [3:0] KindIstore = 4'd1;
  localparam logic [3:0] KindPrint  = 4'd2;
  localparam logic [3:0] KindNot    = 4'd3;
  localparam logic [3:0] KindLt     = 4'd4;
  localparam logic [3:0] KindGt     = 4'd5;
  localparam logic [3:0] KindAdd    = 4'd6;
  localparam logic [3:0] KindSub    = 4'd7;
  localparam logic [3:0] KindMul    = 4'd8;
  localparam logic [3:0] KindDiv    = 4'd9;
  localparam logic [3:0] KindOr     = 4'd10;
  localparam logic [3:0] KindEq     = 4'd11;
  localparam logic [3:0] KindAnd    = 4'd12;

  // Decoded operation; binary ops sit contiguously from OpLt to OpAnd
  typedef enum logic [3:0] {
    OpPush, OpIstore, OpPrint, OpNot,
    OpLt, OpGt, OpAdd, OpSub, OpMul, OpDiv, OpOr, OpEq, OpAnd
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StUnder   = 2'd1,
    StOver    = 2'd2,
    StDivZero = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BkIdle, BkRead, BkDiv, BkCommit
  } bk_state_e;

  typedef struct packed {
    op_e   op;
    data_t imm;
  } cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/tsvm_front.sv
// Front end: classifies an incoming instruction into a queued command.
// Depends on tsvm_pkg.
`default_nettype none

module tsvm_front (
  input  wire logic                  accept_i,
  input  wire logic [3:0]            kind_i,
  input  wire logic [31:0]           immediate_i,
  output tsvm_pkg::cmd_t             cmd_o,
  output logic                       cmd_valid_o
);
  import tsvm_pkg::*;

  logic known;

  always_comb begin
    known     = 1'b1;
    cmd_o.imm = data_t'(immediate_i);
    cmd_o.op  = OpPush;
    case (kind_i)
      KindPush:   cmd_o.op = OpPush;
      KindIstore: cmd_o.op = OpIstore;
      KindPrint:  cmd_o.op = OpPrint;
      KindNot:    cmd_o.op = OpNot;
      KindLt:     cmd_o.op = OpLt;
      KindGt:     cmd_o.op = OpGt;
      KindAdd:    cmd_o.op = OpAdd;
      KindSub:    cmd_o.op = OpSub;
      KindMul:    cmd_o.op = OpMul;
      KindDiv:    cmd_o.op = OpDiv;
      KindOr:     cmd_o.op = OpOr;
      KindEq:     cmd_o.op = OpEq;
      KindAnd:    cmd_o.op = OpAnd;
      // drop unused codes: no result, no state change
      default:    known = 1'b0;
    endcase
    cmd_valid_o = accept_i & known;
  end

endmodule

`default_nettype wire

// File: hw/rtl/tsvm_cmd_q.sv
// Short command queue between the front end and the execution back end.
// Depends on tsvm_pkg.
`default_nettype none

module tsvm_cmd_q (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tsvm_pkg::cmd_t cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output tsvm_pkg::cmd_t      cmd_o,
  output logic                empty_o
);
  import tsvm_pkg::*;

  localparam int PtrW = $clog2(CmdQDepth);
  localparam int QCntW = $clog2(CmdQDepth + 1);

  cmd_t             entry_q [CmdQDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == QCntW'(CmdQDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PtrW'(CmdQDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(CmdQDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tsvm_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on tsvm_pkg.
`default_nettype none

module tsvm_div (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire tsvm_pkg::data_t dividend_i,
  input  wire tsvm_pkg::data_t divisor_i,
  output logic                 done_o,
  output tsvm_pkg::data_t      quotient_o
);
  import tsvm_pkg::*;

  localparam int DivCntW = $clog2(DataWidth);

  logic               busy_q, fin_q, neg_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DataWidth:0] rem_q, rem_sh, trial;
  data_t              quo_q, mag_q;

  assign rem_sh     = {rem_q[DataWidth-1:0], quo_q[DataWidth-1]};
  assign trial      = rem_sh - {1'b0, mag_q};
  assign done_o     = fin_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DataWidth-1] ^ divisor_i[DataWidth-1];
      quo_q <= dividend_i[DataWidth-1] ? (~dividend_i + 1'b1) : dividend_i;
      mag_q <= divisor_i[DataWidth-1] ? (~divisor_i + 1'b1) : divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      // restore on a negative trial
      rem_q <= trial[DataWidth] ? rem_sh : trial;
      quo_q <= {quo_q[DataWidth-2:0], ~trial[DataWidth]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DataWidth - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tsvm_back.sv
// Execution back end: both stacks, checks, ALU, divider and result register.
// Depends on tsvm_pkg and tsvm_div.
`default_nettype none

module tsvm_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tsvm_pkg::cmd_t    cmd_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_pop_o,
  output logic                   res_valid_o,
  output tsvm_pkg::data_t        res_value_o,
  output logic [1:0]             res_status_o,
  input  wire logic              res_pop_i
);
  import tsvm_pkg::*;

  bk_state_e state_q, state_d;

  data_t   opnd_mem [StackDepth];
  data_t   rslt_mem [StackDepth];

  op_e     op_q;
  data_t   imm_q;
  cnt_t    oc_q, rc_q, oc_m1, oc_m2, rc_m1;
  data_t   rd_a_q, rd_b_q, rd_r_q;
  logic    err_q, emit_q;
  status_e st_q;
  data_t   res_q;
  logic    out_valid_q;
  data_t   out_value_q;
  status_e out_status_q;

  logic    rd_en, div_start, div_done, commit_go, out_free;
  logic    chk_err, is_binary;
  status_e chk_st;
  data_t   alu_res, div_q;
  logic    opnd_we, rslt_we;
  logic [AddrW-1:0] opnd_waddr;
  logic    bool_l, bool_r;

  assign oc_m1    = oc_q - 1'b1;
  assign oc_m2    = oc_q - 2'd2;
  assign rc_m1    = rc_q - 1'b1;
  assign out_free = ~out_valid_q | res_pop_i;
  assign is_binary = op_q inside {[OpLt:OpAnd]};

  assign res_valid_o  = out_valid_q;
  assign res_value_o  = out_value_q;
  assign res_status_o = out_status_q;

  tsvm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_b_q),
    .divisor_i  (rd_a_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Checks in order: underflow, overflow, divide by zero
  always_comb begin
    chk_err = 1'b0;
    chk_st  = StOk;
    case (op_q)
      OpPush: begin
        if (oc_q == cnt_t'(StackDepth)) begin chk_err = 1'b1; chk_st = StOver; end
      end
      OpIstore: begin
        if (rc_q == '0) begin chk_err = 1'b1; chk_st = StUnder; end
        else if (oc_q == cnt_t'(StackDepth)) begin chk_err = 1'b1; chk_st = StOver; end
      end
      OpPrint, OpNot: begin
        if (oc_q == '0) begin chk_err = 1'b1; chk_st = StUnder; end
      end
      default: begin
        if (oc_q < cnt_t'(2)) begin chk_err = 1'b1; chk_st = StUnder; end
        else if (rc_q == cnt_t'(StackDepth)) begin chk_err = 1'b1; chk_st = StOver; end
        else if (op_q == OpDiv && rd_a_q == '0) begin
          chk_err = 1'b1;
          chk_st  = StDivZero;
        end
      end
    endcase
  end

  // Left operand is the second entry, right operand the top
  always_comb begin
    bool_l  = |rd_b_q;
    bool_r  = |rd_a_q;
    alu_res = '0;
    case (op_q)
      OpPush:   alu_res = imm_q;
      OpIstore: alu_res = rd_r_q;
      OpPrint:  alu_res = rd_a_q;
      OpNot:    alu_res = data_t'(!bool_r);
      OpLt:     alu_res = data_t'($signed(rd_b_q) < $signed(rd_a_q));
      OpGt:     alu_res = data_t'($signed(rd_b_q) > $signed(rd_a_q));
      OpAdd:    alu_res = rd_b_q + rd_a_q;
      OpSub:    alu_res = rd_b_q - rd_a_q;
      OpMul:    alu_res = rd_b_q * rd_a_q;
      OpOr:     alu_res = data_t'(bool_l | bool_r);
      OpEq:     alu_res = data_t'(bool_l == bool_r);
      OpAnd:    alu_res = data_t'(bool_l & bool_r);
      default:  alu_res = '0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    commit_go = 1'b0;
    case (state_q)
      BkIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          rd_en     = 1'b1;
          state_d   = BkRead;
        end
      end
      BkRead: begin
        if (!chk_err && op_q == OpDiv) begin
          div_start = 1'b1;
          state_d   = BkDiv;
        end else begin
          state_d = BkCommit;
        end
      end
      BkDiv: begin
        if (div_done) state_d = BkCommit;
      end
      BkCommit: begin
        // a command with a result waits while the result register is held and not popped
        if (!emit_q || out_free) begin
          commit_go = 1'b1;
          state_d   = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  assign opnd_we    = commit_go & ~err_q &
                      (op_q == OpPush || op_q == OpIstore || op_q == OpNot);
  assign opnd_waddr = (op_q == OpNot) ? oc_m1[AddrW-1:0] : oc_q[AddrW-1:0];
  assign rslt_we    = commit_go & ~err_q & is_binary;

  always_ff @(posedge clk_i) begin
    if (opnd_we) opnd_mem[opnd_waddr] <= res_q;
    if (rd_en) begin
      rd_a_q <= opnd_mem[oc_m1[AddrW-1:0]];
      rd_b_q <= opnd_mem[oc_m2[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rslt_we) rslt_mem[rc_q[AddrW-1:0]] <= res_q;
    if (rd_en) rd_r_q <= rslt_mem[rc_m1[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      op_q  <= cmd_i.op;
      imm_q <= cmd_i.imm;
    end
    if (state_q == BkRead) begin
      err_q  <= chk_err;
      st_q   <= chk_st;
      emit_q <= chk_err | (op_q == OpPrint);
      res_q  <= alu_res;
    end else if (state_q == BkDiv && div_done) begin
      res_q <= div_q;
    end
    if (commit_go && emit_q) begin
      out_value_q  <= err_q ? '0 : res_q;
      out_status_q <= st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      oc_q        <= '0;
      rc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit_go && emit_q)  out_valid_q <= 1'b1;
      else if (res_pop_i)       out_valid_q <= 1'b0;
      if (commit_go && !err_q) begin
        case (op_q)
          OpPush:   oc_q <= oc_q + 1'b1;
          OpIstore: begin
            oc_q <= oc_q + 1'b1;
            rc_q <= rc_m1;
          end
          OpPrint:  oc_q <= oc_m1;
          OpNot:    oc_q <= oc_q;
          default: begin
            oc_q <= oc_m2;
            rc_q <= rc_q + 1'b1;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/two_stack_integer_vm.sv
// Top level of the two-stack integer VM.
// Depends on tsvm_pkg, tsvm_front, tsvm_cmd_q and tsvm_back.
//
//   channel       transaction when      payload
//   -----------   -------------------   ---------------------------------
//   instruction   push  && !full        kind_i[3:0], immediate_i[31:0]
//   result        pop   && !empty       value_o[31:0], status_o[1:0]
//
// Each instruction passes the back end in order: dequeue and stack read,
// check and ALU, commit. A division adds the serial divider, one quotient
// bit per cycle; that loop sets the worst-case rate. A two-entry command
// queue takes new instructions while the back end works, and a result
// register holds a finished transaction until popped; a command with a
// result stalls at commit while that register is full and not popped.
// Reset clears stack counts, the queue, back-end state, divider control and result valid only.
`default_nettype none

module two_stack_integer_vm (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [3:0]         kind_i,
  input  wire logic signed [31:0] immediate_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      value_o,
  output logic [1:0]              status_o
);
  import tsvm_pkg::*;

  cmd_t  fe_cmd, q_cmd;
  logic  fe_valid, q_full, q_empty, q_pop;
  logic  res_valid;
  data_t res_value;

  // Accept whenever the queue has room; unused codes are dropped in front
  tsvm_front u_front (
    .accept_i    (push & ~q_full),
    .kind_i      (kind_i),
    .immediate_i (immediate_i),
    .cmd_o       (fe_cmd),
    .cmd_valid_o (fe_valid)
  );

  tsvm_cmd_q u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .cmd_i   (fe_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty)
  );

  tsvm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (q_cmd),
    .cmd_valid_i  (~q_empty),
    .cmd_pop_o    (q_pop),
    .res_valid_o  (res_valid),
    .res_value_o  (res_value),
    .res_status_o (status_o),
    .res_pop_i    (pop)
  );

  assign full    = q_full;
  assign empty   = ~res_valid;
  assign value_o = $signed(res_value);

endmodule

`default_nettype wire

// File: dv/tb_two_stack_integer_vm.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-stack integer VM.
// Holds a scoreboard class with its own stack predictor; drives the block
// through its queue-style ports. Depends on tsvm_pkg and two_stack_integer_vm.

module tb_two_stack_integer_vm;
  import tsvm_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 9;
  // A division holds the back end through the serial divider with two more queued
  // behind it, and the receiver may stall on top of that; leave wide margin.
  localparam int QuietLimit  = 5000;
  localparam int DrainCycles = 150;
  localparam int RandomItems = 1320;

  localparam data_t MostNeg = {1'b1, {(DataWidth-1){1'b0}}};
  localparam data_t MostPos = {1'b0, {(DataWidth-1){1'b1}}};

  // Random program styles: balanced, grow the operand stack, grow results
  localparam int StyleBalanced = 0;
  localparam int StyleDeepOpnd = 1;
  localparam int StyleDeepRslt = 2;

  typedef struct packed {
    data_t      value;
    logic [1:0] status;
  } vm_result_t;

  // Tracks both stacks as instructions are accepted and queues the printed
  // values and error codes the block must return, in order.
  class vm_scoreboard;
    data_t      opnd_stk[StackDepth];
    int         opnd_cnt;
    data_t      rslt_stk[StackDepth];
    int         rslt_cnt;
    vm_result_t pending_q[$];
    int         n_instr;
    int         n_ignored;
    int         n_status[4];
    int         n_checked;
    int         n_errors;

    function new();
      opnd_cnt  = 0;
      rslt_cnt  = 0;
      n_instr   = 0;
      n_ignored = 0;
      n_checked = 0;
      n_errors  = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function void queue_result(data_t value, logic [1:0] status);
      vm_result_t item;
      item.value  = value;
      item.status = status;
      pending_q.push_back(item);
      n_status[status]++;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Advance the stack model by one accepted instruction.
    function void note_instr(logic [3:0] kind, data_t imm);
      data_t lhs;
      data_t rhs;
      data_t res;
      n_instr++;
      case (kind)
        KindPush: begin
          if (opnd_cnt >= StackDepth) queue_result('0, StOver);
          else begin
            opnd_stk[opnd_cnt] = imm;
            opnd_cnt++;
          end
        end
        KindIstore: begin
          if (rslt_cnt == 0) queue_result('0, StUnder);
          else if (opnd_cnt >= StackDepth) queue_result('0, StOver);
          else begin
            rslt_cnt--;
            opnd_stk[opnd_cnt] = rslt_stk[rslt_cnt];
            opnd_cnt++;
          end
        end
        KindPrint: begin
          if (opnd_cnt == 0) queue_result('0, StUnder);
          else begin
            opnd_cnt--;
            queue_result(opnd_stk[opnd_cnt], StOk);
          end
        end
        KindNot: begin
          if (opnd_cnt == 0) queue_result('0, StUnder);
          else opnd_stk[opnd_cnt-1] = data_t'(!(|opnd_stk[opnd_cnt-1]));
        end
        KindLt, KindGt, KindAdd, KindSub, KindMul, KindDiv,
        KindOr, KindEq, KindAnd: begin
          // Underflow wins over overflow, overflow over divide by zero
          if (opnd_cnt < 2) queue_result('0, StUnder);
          else if (rslt_cnt >= StackDepth) queue_result('0, StOver);
          else begin
            rhs = opnd_stk[opnd_cnt-1];
            lhs = opnd_stk[opnd_cnt-2];
            if (kind == KindDiv && rhs == '0) queue_result('0, StDivZero);
            else begin
              case (kind)
                KindLt:  res = data_t'($signed(lhs) < $signed(rhs));
                KindGt:  res = data_t'($signed(lhs) > $signed(rhs));
                KindAdd: res = lhs + rhs;
                KindSub: res = lhs - rhs;
                KindMul: res = lhs * rhs;
                KindDiv: begin
                  // Most negative by minus one wraps back to itself
                  if (lhs == MostNeg && rhs == '1) res = MostNeg;
                  else res = data_t'($signed(lhs) / $signed(rhs));
                end
                KindOr:  res = data_t'((|lhs) || (|rhs));
                KindEq:  res = data_t'((|lhs) == (|rhs));
                default: res = data_t'((|lhs) && (|rhs));
              endcase
              opnd_cnt -= 2;
              rslt_stk[rslt_cnt] = res;
              rslt_cnt++;
            end
          end
        end
        default: n_ignored++;
      endcase
    endfunction

    // Compare one popped result with the oldest pending one.
    function void check_result(data_t value, logic [1:0] status);
      vm_result_t want;
      n_checked++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %h status %0d",
                 $time, value, status);
        n_errors++;
        return;
      end
      want = pending_q.pop_front();
      if (value !== want.value) begin
        $display("%0t: value mismatch: expected %h, actual %h",
                 $time, want.value, value);
        n_errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, status);
        n_errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [3:0]         kind_i;
  logic signed [31:0] immediate_i;
  logic               empty;
  logic               pop;
  logic signed [31:0] value_o;
  logic [1:0]         status_o;

  vm_scoreboard sb;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           quiet_cycles;

  two_stack_integer_vm dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .immediate_i (immediate_i),
    .empty       (empty),
    .pop         (pop),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Hand one instruction to the block. Call at a falling edge; returns at
  // the falling edge after the transaction with push still high, so that
  // back-to-back items keep push asserted without a glitch.
  task automatic send_instr(logic [3:0] kind, data_t imm);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push        = 1'b1;
    kind_i      = kind;
    immediate_i = imm;
    do @(posedge clk_i); while (full);
    sb.note_instr(kind, imm);
    @(negedge clk_i);
  endtask

  // Drop push and hold off until every pending result has been popped.
  task automatic wait_drained();
    push = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Immediates: mostly full-range, with small values (zero divisors, false
  // operands) and the extremes mixed in.
  function automatic data_t pick_imm();
    case ($urandom_range(0, 7))
      0, 1: return data_t'($urandom_range(0, 8) - 4);
      2: begin
        case ($urandom_range(0, 4))
          0: return MostNeg;
          1: return MostPos;
          2: return '1;
          3: return '0;
          default: return data_t'(1);
        endcase
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  // Choose an instruction that is legal for the current stack depths,
  // weighted by program style.
  function automatic logic [3:0] pick_kind(int style);
    int w_push;
    int w_store;
    int w_print;
    int w_not;
    int w_bin;
    int roll;
    case (style)
      StyleDeepOpnd: begin
        w_push = 8; w_store = 3; w_print = 1; w_not = 1; w_bin = 1;
      end
      StyleDeepRslt: begin
        w_push = 5; w_store = 0; w_print = 0; w_not = 1; w_bin = 5;
      end
      default: begin
        w_push = 4; w_store = 3; w_print = 3; w_not = 1; w_bin = 3;
      end
    endcase
    if (sb.opnd_cnt >= StackDepth) w_push = 0;
    if (sb.rslt_cnt == 0 || sb.opnd_cnt >= StackDepth) w_store = 0;
    if (sb.opnd_cnt == 0) begin
      w_print = 0;
      w_not   = 0;
    end
    if (sb.opnd_cnt < 2 || sb.rslt_cnt >= StackDepth) w_bin = 0;
    // Empty operand stack always allows a push, so the total is never zero
    roll = $urandom_range(0, w_push + w_store + w_print + w_not + w_bin - 1);
    if (roll < w_push) return KindPush;
    roll -= w_push;
    if (roll < w_store) return KindIstore;
    roll -= w_store;
    if (roll < w_print) return KindPrint;
    roll -= w_print;
    if (roll < w_not) return KindNot;
    return 4'($urandom_range(KindLt, KindAnd));
  endfunction

  // Mostly well-formed programs with random operands; a slice of raw noise
  // brings in the error paths and the unused kind codes.
  task automatic run_random(int count);
    int         done;
    int         style;
    logic [3:0] kind;
    done  = 0;
    style = StyleBalanced;
    while (done < count) begin
      if ($urandom_range(0, 99) < 3) style = $urandom_range(StyleBalanced, StyleDeepRslt);
      if ($urandom_range(0, 99) < 8) kind = 4'($urandom_range(0, 15));
      else kind = pick_kind(style);
      if (kind <= KindAnd) done++;
      send_instr(kind, pick_imm());
    end
  endtask

  // Errors on empty stacks, extreme values, wraparound and every opcode.
  task automatic run_directed();
    send_instr(KindPrint,  '0);          // print with nothing on the stack
    send_instr(KindNot,    '0);          // not with nothing on the stack
    send_instr(KindIstore, '0);          // no result to move back
    send_instr(KindAdd,    '0);          // binary op without operands
    send_instr(KindPush,   MostNeg);
    send_instr(KindAdd,    '0);          // binary op with a single operand
    send_instr(KindPush,   '1);
    send_instr(KindDiv,    '0);          // most negative over minus one
    send_instr(KindIstore, '0);
    send_instr(KindPrint,  '0);
    send_instr(KindPush,   data_t'(4));
    send_instr(KindPush,   '0);
    send_instr(KindDiv,    '0);          // divide by zero leaves stacks alone
    send_instr(KindNot,    '0);
    send_instr(KindGt,     '0);
    send_instr(4'hd,       MostPos);     // unused code, no effect
    send_instr(KindPush,   MostPos);
    send_instr(KindPush,   data_t'(1));
    send_instr(KindAdd,    '0);          // signed wrap
    send_instr(KindPush,   data_t'(-6));
    send_instr(KindPush,   data_t'(7));
    send_instr(KindMul,    '0);
    send_instr(KindPush,   data_t'(3));
    send_instr(KindPush,   data_t'(9));
    send_instr(KindSub,    '0);
    send_instr(KindIstore, '0);
    send_instr(KindIstore, '0);
    send_instr(KindLt,     '0);
    send_instr(KindIstore, '0);
    send_instr(KindIstore, '0);
    send_instr(KindOr,     '0);
    send_instr(KindIstore, '0);
    send_instr(KindPush,   '0);
    send_instr(KindEq,     '0);
    send_instr(KindIstore, '0);
    send_instr(KindPush,   '1);
    send_instr(KindAnd,    '0);
  endtask

  // Result side: decide pop at the falling edge, check at the rising edge.
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pop = ($urandom_range(0, 99) >= recv_stall_pct);
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(data_t'(value_o), status_o);
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles, %0d results pending",
                 $time, quiet_cycles, sb.pending());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    push           = 1'b0;
    kind_i         = '0;
    immediate_i    = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Full rate on both sides
    run_directed();
    run_random(RandomItems / 4);

    // Sparse sender; pause mid-phase until every result is back
    send_idle_pct = 75;
    run_random(RandomItems / 8);
    wait_drained();
    run_random(RandomItems / 8);

    // Slow receiver, backs up the result register and command queue
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    run_random(RandomItems / 4);

    // Both sides idle at random
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    run_random(RandomItems / 4);

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);

    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
      sb.n_errors++;
    end
    $display("Ran %0d instructions (%0d with unused codes), checked %0d results",
             sb.n_instr, sb.n_ignored, sb.n_checked);
    $display("Printed %0d; underflow %0d, overflow %0d, divide by zero %0d",
             sb.n_status[StOk], sb.n_status[StUnder], sb.n_status[StOver],
             sb.n_status[StDivZero]);
    if (sb.n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tsvm_pkg.sv
hw/rtl/tsvm_front.sv
hw/rtl/tsvm_cmd_q.sv
hw/rtl/tsvm_div.sv
hw/rtl/tsvm_back.sv
hw/rtl/two_stack_integer_vm.sv
dv/tb_two_stack_integer_vm.sv
